[hdl/sdsc_pkg.sv]
// Shared widths and DER tag constants for the strict DER signature checker.
package sdsc_pkg;

  // Channel widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned POS_W      = 7;

  // DER codes and framing constants
  localparam logic [7:0]       SEQ_TAG        = 8'h30;
  localparam logic [7:0]       INT_TAG        = 8'h02;
  localparam int unsigned      SIGN_BIT_IDX   = 7;
  localparam logic [POS_W-1:0] POS_LIMIT      = 7'd127;
  localparam logic [7:0]       MIN_SIG_BYTES  = 8'd8;
  localparam logic [9:0]       FIXED_OVERHEAD = 10'd6;

endpackage

[hdl/strict_der_signature_check.sv]
// The verdict for a signature is registered and appears in the cycle after its end-marked byte is taken.
// Throughput: one byte per cycle unless stalled; each byte updates the length and flag registers in one pass.
// The input stalls only while a verdict is held and not yet taken on the output side.
// Reset (rst_n low, synchronous) clears the byte position, lengths, flags and output valid.
// All check state also clears after every verdict.
module strict_der_signature_check #(
  parameter int unsigned MAX_SIG_BYTES = 72
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sdsc_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] sig_byte
  input  logic                            in_tlast,   // end_of_signature
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sdsc_pkg::OUT_DATA_W-1:0] out_tdata   // [0] strict_der_ok, [7:1] zero
);
  import sdsc_pkg::*;

  localparam logic [7:0] MaxTotal = 8'(MAX_SIG_BYTES);

  // Check state
  logic [POS_W-1:0] pos_r,      pos_nxt;
  logic [7:0]       decl_len_r, decl_len_nxt;
  logic [7:0]       r_len_r,    r_len_nxt;
  logic [7:0]       s_len_r,    s_len_nxt;
  logic             r_lz_r,     r_lz_nxt;
  logic             s_lz_r,     s_lz_nxt;
  logic             fail_r,     fail_nxt;

  // Result register
  logic             out_valid_r;
  logic             out_ok_r;

  logic             in_accept;
  logic [8:0]       pos9;
  logic [8:0]       s_tag;
  logic             b_neg;
  logic [7:0]       total;
  logic             verdict_ok;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign pos9      = {2'b00, pos_r};
  assign s_tag     = 9'd4 + {1'b0, r_len_r};
  assign b_neg     = in_tdata[SIGN_BIT_IDX];
  assign total     = {1'b0, pos_r} + 8'd1;

  // Update field captures and sticky failure for the current byte
  always_comb begin
    decl_len_nxt = decl_len_r;
    r_len_nxt    = r_len_r;
    s_len_nxt    = s_len_r;
    r_lz_nxt     = r_lz_r;
    s_lz_nxt     = s_lz_r;
    fail_nxt     = fail_r;

    // Header and R integer by fixed position
    case (pos_r)
      7'd0: if (in_tdata != SEQ_TAG) fail_nxt = 1'b1;
      7'd1: decl_len_nxt = in_tdata;
      7'd2: if (in_tdata != INT_TAG) fail_nxt = 1'b1;
      7'd3: r_len_nxt = in_tdata;
      7'd4: begin
        if (b_neg) fail_nxt = 1'b1;
        r_lz_nxt = (in_tdata == 8'd0);
      end
      7'd5: if (r_len_r > 8'd1 && r_lz_r && !b_neg) fail_nxt = 1'b1;
      default: ;
    endcase

    // S integer, placed after R
    if (r_len_r != 8'd0 && pos_r >= 7'd5) begin
      if (pos9 == s_tag) begin
        if (in_tdata != INT_TAG) fail_nxt = 1'b1;
      end else if (pos9 == s_tag + 9'd1) begin
        s_len_nxt = in_tdata;
      end else if (pos9 == s_tag + 9'd2) begin
        if (b_neg) fail_nxt = 1'b1;
        s_lz_nxt = (in_tdata == 8'd0);
      end else if (pos9 == s_tag + 9'd3) begin
        if (s_len_r > 8'd1 && s_lz_r && !b_neg) fail_nxt = 1'b1;
      end
    end

    pos_nxt = (pos_r < POS_LIMIT) ? pos_r + 7'd1 : POS_LIMIT;
  end

  // Combine the sticky failure with the length rules against the final count
  always_comb begin
    verdict_ok = !fail_nxt;
    if (total < MIN_SIG_BYTES || total > MaxTotal) verdict_ok = 1'b0;
    if ({1'b0, decl_len_nxt} + 9'd2 != {1'b0, total}) verdict_ok = 1'b0;
    if (r_len_nxt == 8'd0 || {1'b0, r_len_nxt} + 9'd5 >= {1'b0, total}) verdict_ok = 1'b0;
    if (s_len_nxt == 8'd0) verdict_ok = 1'b0;
    if ({2'b00, r_len_nxt} + {2'b00, s_len_nxt} + FIXED_OVERHEAD != {2'b00, total})
      verdict_ok = 1'b0;
  end

  // Hold check state; clear it after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      decl_len_r <= '0;
      r_len_r    <= '0;
      s_len_r    <= '0;
      r_lz_r     <= 1'b0;
      s_lz_r     <= 1'b0;
      fail_r     <= 1'b0;
    end else if (in_accept) begin
      if (in_tlast) begin
        pos_r      <= '0;
        decl_len_r <= '0;
        r_len_r    <= '0;
        s_len_r    <= '0;
        r_lz_r     <= 1'b0;
        s_lz_r     <= 1'b0;
        fail_r     <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        decl_len_r <= decl_len_nxt;
        r_len_r    <= r_len_nxt;
        s_len_r    <= s_len_nxt;
        r_lz_r     <= r_lz_nxt;
        s_lz_r     <= s_lz_nxt;
        fail_r     <= fail_nxt;
      end
    end
  end

  // Load the verdict; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_tlast) begin
      out_ok_r <= verdict_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_ok_r};

endmodule

[hdl/sdsc_checker.sv]
// Port-level checks for the strict DER signature checker, bound to the top level.
module sdsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sdsc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sdsc_pkg::*;

  // A stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed or vanished while stalled");

  // An end-marked item always yields a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no verdict after end-marked item");

  // A plain item with the output draining produces no verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("verdict without end-marked item");

  // A waiting verdict stalls the input side
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while verdict blocked");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind strict_der_signature_check sdsc_checker u_sdsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
